// File: hdl/suv_pkg.sv
package suv_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int DIR_W      = 16;
    localparam int TEX_W      = 16;
    localparam int TURN_W     = 32;
    // Datapath width of the rotators: Q1.15 scaled by 2^16, negated, times CORDIC gain
    localparam int CDC_W      = 36;
    localparam int FRAC_SHIFT = 16;
    localparam int RAD_W      = 32;
    localparam int SQRT_STEPS = 16;
    localparam int MAG_W      = 16;

    typedef logic signed [DIR_W-1:0]  dir_t;
    typedef logic [TEX_W-1:0]         tex_t;
    typedef logic [TURN_W-1:0]        turn_t;
    typedef logic signed [CDC_W-1:0]  cdc_t;
    typedef logic [RAD_W-1:0]         rad_t;

    localparam turn_t HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in turns, Q0.32, rounded to nearest
    function automatic turn_t turn_angle(input int idx);
        turn_t a;
        case (idx)
            0:  a = 32'h2000_0000;
            1:  a = 32'h12E4_051E;
            2:  a = 32'h09FB_385B;
            3:  a = 32'h0511_11D4;
            4:  a = 32'h028B_0D43;
            5:  a = 32'h0145_D7E1;
            6:  a = 32'h00A2_F61E;
            7:  a = 32'h0051_7C55;
            8:  a = 32'h0028_BE53;
            9:  a = 32'h0014_5F2F;
            10: a = 32'h000A_2F98;
            11: a = 32'h0005_17CC;
            12: a = 32'h0002_8BE6;
            13: a = 32'h0001_45F3;
            14: a = 32'h0000_A2FA;
            15: a = 32'h0000_517D;
            16: a = 32'h0000_28BE;
            17: a = 32'h0000_145F;
            18: a = 32'h0000_0A30;
            19: a = 32'h0000_0518;
            20: a = 32'h0000_028C;
            21: a = 32'h0000_0146;
            22: a = 32'h0000_00A3;
            23: a = 32'h0000_0051;
            24: a = 32'h0000_0029;
            25: a = 32'h0000_0014;
            26: a = 32'h0000_000A;
            27: a = 32'h0000_0005;
            28: a = 32'h0000_0003;
            29: a = 32'h0000_0001;
            30: a = 32'h0000_0001;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/suv_cordic_cell.sv
module suv_cordic_cell #(
    parameter int STAGE = 0,
    parameter int PW    = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           vld_in,
    input  suv_pkg::cdc_t  x_in,
    input  suv_pkg::cdc_t  y_in,
    input  suv_pkg::turn_t ang_in,
    input  logic [PW-1:0]  pay_in,
    output logic           vld_out,
    output suv_pkg::cdc_t  x_out,
    output suv_pkg::cdc_t  y_out,
    output suv_pkg::turn_t ang_out,
    output logic [PW-1:0]  pay_out
);
    import suv_pkg::*;

    localparam turn_t STEP_ANG = turn_angle(STAGE);

    cdc_t          xs;
    cdc_t          ys;
    cdc_t          x_next;
    cdc_t          y_next;
    turn_t         ang_next;
    logic          vld_reg;
    cdc_t          x_reg;
    cdc_t          y_reg;
    turn_t         ang_reg;
    logic [PW-1:0] pay_reg;

    // Rotate towards the x axis: direction follows the sign of y (zero counts as negative)
    always_comb begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!y_in[CDC_W-1] && (y_in != '0)) begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            ang_next = ang_in + STEP_ANG;
        end else begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            ang_next = ang_in - STEP_ANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
            pay_reg <= pay_in;
        end
    end

    assign vld_out = vld_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;
    assign pay_out = pay_reg;

endmodule

// File: hdl/suv_sqrt_cell.sv
module suv_sqrt_cell #(
    parameter int STEP = 0,
    parameter int PW   = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          vld_in,
    input  suv_pkg::rad_t n_in,
    input  suv_pkg::rad_t res_in,
    input  logic [PW-1:0] pay_in,
    output logic          vld_out,
    output suv_pkg::rad_t n_out,
    output suv_pkg::rad_t res_out,
    output logic [PW-1:0] pay_out
);
    import suv_pkg::*;

    localparam int   BIT_POS = RAD_W - 2 - 2 * STEP;
    localparam rad_t BIT_VAL = rad_t'(1) << BIT_POS;

    logic [RAD_W:0] trial;
    rad_t           n_next;
    rad_t           res_next;
    logic           vld_reg;
    rad_t           n_reg;
    rad_t           res_reg;
    logic [PW-1:0]  pay_reg;

    // One digit of the restoring square root
    always_comb begin
        trial = {1'b0, res_in} + {1'b0, BIT_VAL};
        if ({1'b0, n_in} >= trial) begin
            n_next   = n_in - trial[RAD_W-1:0];
            res_next = (res_in >> 1) + BIT_VAL;
        end else begin
            n_next   = n_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            n_reg   <= n_next;
            res_reg <= res_next;
            pay_reg <= pay_in;
        end
    end

    assign vld_out = vld_reg;
    assign n_out   = n_reg;
    assign res_out = res_reg;
    assign pay_out = pay_reg;

endmodule

// File: hdl/sphere_uv_mapper.sv
// Equirectangular texture mapper: one unit direction in, one (u, v) pair out.
// Input channel s_valid/s_ready carries dir_x, dir_y, dir_z in signed Q1.15;
// result channel m_valid/m_ready carries tex_u, tex_v as unsigned 0.16 turns.
// u = 0.5 + atan2(z, x) / 2pi and v = 0.5 - atan2(y, |xz|) / pi, modulo one.
// Throughput: one transfer per cycle on each side, sustained while m_ready stays high.
// Registers from the input transfer to the output register, in order: the
// square stage, the sum and longitude set-up stage, the longitude rotator
// (CORDIC_STAGES cells), the square root (16 digit cells), the latitude
// set-up stage, the latitude rotator (CORDIC_STAGES cells) and the output
// register.
// A two-entry output buffer (output register plus skid register) parts the
// chain from the receiver: while m_ready is low the chain keeps advancing
// until the skid register fills, and s_ready drops only then.
// Reset (aresetn low, synchronous) empties every stage and the buffer; no
// clearing pass is needed, the block holds no state between items.
module sphere_uv_mapper #(
    parameter int COORD_BITS    = suv_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STAGES = suv_pkg::CORDIC_STAGES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  suv_pkg::dir_t s_dir_x,
    input  suv_pkg::dir_t s_dir_y,
    input  suv_pkg::dir_t s_dir_z,
    output logic          m_valid,
    input  logic          m_ready,
    output suv_pkg::tex_t m_tex_u,
    output suv_pkg::tex_t m_tex_v
);
    import suv_pkg::*;

    localparam int LON_PW = 1 + RAD_W + DIR_W;   // {zero, radicand, y}
    localparam int SQ_PW  = TURN_W + DIR_W;      // {longitude, y}
    localparam int LAT_PW = 1 + TURN_W;          // {zero, longitude}
    localparam int SH     = TURN_W - COORD_BITS;

    // Whole chain advances while the skid register is empty
    logic ce;

    // Square stage
    logic                    vld_a_reg;
    dir_t                    x_a_reg;
    dir_t                    y_a_reg;
    dir_t                    z_a_reg;
    logic signed [RAD_W-1:0] sqx_a_reg;
    logic signed [RAD_W-1:0] sqz_a_reg;

    // Sum and longitude set-up stage
    logic          vld_b_reg;
    cdc_t          lx_b_reg;
    cdc_t          ly_b_reg;
    turn_t         lang_b_reg;
    logic          lzero_b_reg;
    rad_t          n_b_reg;
    dir_t          y_b_reg;
    cdc_t          lx_b_next;
    cdc_t          ly_b_next;
    turn_t         lang_b_next;

    logic              lon_vld [0:CORDIC_STAGES];
    cdc_t              lon_x   [0:CORDIC_STAGES];
    cdc_t              lon_y   [0:CORDIC_STAGES];
    turn_t             lon_ang [0:CORDIC_STAGES];
    logic [LON_PW-1:0] lon_pay [0:CORDIC_STAGES];
    turn_t             lon_fin;

    logic             sq_vld [0:SQRT_STEPS];
    rad_t             sq_n   [0:SQRT_STEPS];
    rad_t             sq_res [0:SQRT_STEPS];
    logic [SQ_PW-1:0] sq_pay [0:SQRT_STEPS];

    // Latitude set-up stage
    logic          vld_c_reg;
    cdc_t          tx_c_reg;
    cdc_t          ty_c_reg;
    logic          tzero_c_reg;
    turn_t         lon_c_reg;
    logic [MAG_W-1:0] mag;
    dir_t          y_sq;

    logic              lat_vld [0:CORDIC_STAGES];
    cdc_t              lat_x   [0:CORDIC_STAGES];
    cdc_t              lat_y   [0:CORDIC_STAGES];
    turn_t             lat_ang [0:CORDIC_STAGES];
    logic [LAT_PW-1:0] lat_pay [0:CORDIC_STAGES];
    turn_t             lat_fin;

    turn_t u_turn;
    turn_t v_turn;
    logic [COORD_BITS-1:0] u_crd;
    logic [COORD_BITS-1:0] v_crd;
    tex_t  fin_u;
    tex_t  fin_v;
    logic  fin_vld;

    // Output buffer
    logic out_vld_reg, out_vld_next;
    tex_t out_u_reg, out_u_next;
    tex_t out_v_reg, out_v_next;
    logic skid_vld_reg, skid_vld_next;
    tex_t skid_u_reg, skid_u_next;
    tex_t skid_v_reg, skid_v_next;

    assign ce      = !skid_vld_reg;
    assign s_ready = ce;

    // ---------------------------------------------------------------- squares
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (ce) begin
            vld_a_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_a_reg   <= s_dir_x;
            y_a_reg   <= s_dir_y;
            z_a_reg   <= s_dir_z;
            sqx_a_reg <= RAD_W'(s_dir_x) * RAD_W'(s_dir_x);
            sqz_a_reg <= RAD_W'(s_dir_z) * RAD_W'(s_dir_z);
        end
    end

    // ------------------------------------------- radicand, longitude set-up
    // Fold the left half-plane onto the right by negating and adding half a turn
    always_comb begin
        lx_b_next   = cdc_t'(x_a_reg) <<< FRAC_SHIFT;
        ly_b_next   = cdc_t'(z_a_reg) <<< FRAC_SHIFT;
        lang_b_next = '0;
        if (x_a_reg[DIR_W-1]) begin
            lx_b_next   = -lx_b_next;
            ly_b_next   = -ly_b_next;
            lang_b_next = HALF_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_b_reg <= 1'b0;
        end else if (ce) begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lx_b_reg    <= lx_b_next;
            ly_b_reg    <= ly_b_next;
            lang_b_reg  <= lang_b_next;
            lzero_b_reg <= (x_a_reg == '0) && (z_a_reg == '0);
            n_b_reg     <= rad_t'(sqx_a_reg) + rad_t'(sqz_a_reg);
            y_b_reg     <= y_a_reg;
        end
    end

    // ------------------------------------------------------ longitude rotator
    assign lon_vld[0] = vld_b_reg;
    assign lon_x[0]   = lx_b_reg;
    assign lon_y[0]   = ly_b_reg;
    assign lon_ang[0] = lang_b_reg;
    assign lon_pay[0] = {lzero_b_reg, n_b_reg, y_b_reg};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_lon
        suv_cordic_cell #(
            .STAGE (g),
            .PW    (LON_PW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .vld_in  (lon_vld[g]),
            .x_in    (lon_x[g]),
            .y_in    (lon_y[g]),
            .ang_in  (lon_ang[g]),
            .pay_in  (lon_pay[g]),
            .vld_out (lon_vld[g+1]),
            .x_out   (lon_x[g+1]),
            .y_out   (lon_y[g+1]),
            .ang_out (lon_ang[g+1]),
            .pay_out (lon_pay[g+1])
        );
    end

    // Direction along the polar axis: longitude is taken as zero
    assign lon_fin = lon_pay[CORDIC_STAGES][LON_PW-1] ? '0 : lon_ang[CORDIC_STAGES];

    // ------------------------------------------------------------ square root
    assign sq_vld[0] = lon_vld[CORDIC_STAGES];
    assign sq_n[0]   = lon_pay[CORDIC_STAGES][RAD_W+DIR_W-1:DIR_W];
    assign sq_res[0] = '0;
    assign sq_pay[0] = {lon_fin, lon_pay[CORDIC_STAGES][DIR_W-1:0]};

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        suv_sqrt_cell #(
            .STEP (k),
            .PW   (SQ_PW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .vld_in  (sq_vld[k]),
            .n_in    (sq_n[k]),
            .res_in  (sq_res[k]),
            .pay_in  (sq_pay[k]),
            .vld_out (sq_vld[k+1]),
            .n_out   (sq_n[k+1]),
            .res_out (sq_res[k+1]),
            .pay_out (sq_pay[k+1])
        );
    end

    // ------------------------------------------------------- latitude set-up
    assign mag  = sq_res[SQRT_STEPS][MAG_W-1:0];
    assign y_sq = sq_pay[SQRT_STEPS][DIR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_c_reg <= 1'b0;
        end else if (ce) begin
            vld_c_reg <= sq_vld[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tx_c_reg    <= cdc_t'({1'b0, mag}) <<< FRAC_SHIFT;
            ty_c_reg    <= cdc_t'(y_sq) <<< FRAC_SHIFT;
            tzero_c_reg <= (mag == '0) && (y_sq == '0);
            lon_c_reg   <= sq_pay[SQRT_STEPS][SQ_PW-1:DIR_W];
        end
    end

    // ------------------------------------------------------- latitude rotator
    assign lat_vld[0] = vld_c_reg;
    assign lat_x[0]   = tx_c_reg;
    assign lat_y[0]   = ty_c_reg;
    assign lat_ang[0] = '0;
    assign lat_pay[0] = {tzero_c_reg, lon_c_reg};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_lat
        suv_cordic_cell #(
            .STAGE (g),
            .PW    (LAT_PW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .vld_in  (lat_vld[g]),
            .x_in    (lat_x[g]),
            .y_in    (lat_y[g]),
            .ang_in  (lat_ang[g]),
            .pay_in  (lat_pay[g]),
            .vld_out (lat_vld[g+1]),
            .x_out   (lat_x[g+1]),
            .y_out   (lat_y[g+1]),
            .ang_out (lat_ang[g+1]),
            .pay_out (lat_pay[g+1])
        );
    end

    assign lat_fin = lat_pay[CORDIC_STAGES][LAT_PW-1] ? '0 : lat_ang[CORDIC_STAGES];

    // ----------------------------------------------- coordinates and rounding
    // Both sums wrap modulo one turn
    assign u_turn = HALF_TURN + lat_pay[CORDIC_STAGES][TURN_W-1:0];
    assign v_turn = HALF_TURN - (lat_fin << 1);

    if (SH > 0) begin : g_round
        localparam logic [TURN_W:0] RND = (TURN_W+1)'(1) << (SH - 1);
        logic [TURN_W:0] u_sum;
        logic [TURN_W:0] v_sum;
        // Round half up, drop the carry out so that one turn wraps to zero
        assign u_sum = {1'b0, u_turn} + RND;
        assign v_sum = {1'b0, v_turn} + RND;
        assign u_crd = u_sum[TURN_W-1:SH];
        assign v_crd = v_sum[TURN_W-1:SH];
    end else begin : g_full
        assign u_crd = u_turn;
        assign v_crd = v_turn;
    end

    if (COORD_BITS >= TEX_W) begin : g_trunc
        assign fin_u = u_crd[TEX_W-1:0];
        assign fin_v = v_crd[TEX_W-1:0];
    end else begin : g_ext
        assign fin_u = TEX_W'(u_crd);
        assign fin_v = TEX_W'(v_crd);
    end

    assign fin_vld = lat_vld[CORDIC_STAGES];

    // ---------------------------------------------------------- output buffer
    // Hold the output while stalled and catch the item leaving the chain in the
    // skid register; drain the skid register first once the receiver is free.
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_u_next    = out_u_reg;
        out_v_next    = out_v_reg;
        skid_vld_next = skid_vld_reg;
        skid_u_next   = skid_u_reg;
        skid_v_next   = skid_v_reg;
        if (out_vld_reg && !m_ready) begin
            if (ce && fin_vld) begin
                skid_vld_next = 1'b1;
                skid_u_next   = fin_u;
                skid_v_next   = fin_v;
            end
        end else if (skid_vld_reg) begin
            out_vld_next  = 1'b1;
            out_u_next    = skid_u_reg;
            out_v_next    = skid_v_reg;
            skid_vld_next = 1'b0;
        end else begin
            out_vld_next = fin_vld;
            out_u_next   = fin_u;
            out_v_next   = fin_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_u_reg  <= out_u_next;
        out_v_reg  <= out_v_next;
        skid_u_reg <= skid_u_next;
        skid_v_reg <= skid_v_next;
    end

    assign m_valid = out_vld_reg;
    assign m_tex_u = out_u_reg;
    assign m_tex_v = out_v_reg;

endmodule
